[hdl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the sensor calibration compensator.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned DIV_STAGES = 32;   // one quotient bit per stage

  localparam logic [31:0] PRES_MAX = 32'd131071;
  localparam logic [31:0] HUM_PRE_MAX = 32'd419430400;

  // item data that rides beside the divider and the post stages
  typedef struct packed {
    logic        zero;    // pressure divisor was zero
    logic        big;     // dividend had bit 31 set
    logic [14:0] temp;
    logic [31:0] tf;
    logic [31:0] hx;      // humidity product before the final correction
  } side_t;

endpackage

[hdl/scc_div.sv]
// ----------------------------------------------------------------------------
// scc_div
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module scc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [31:0]      in_num,
  input  logic [31:0]      in_den,
  input  scc_pkg::side_t   in_side,
  output logic             out_vld,
  output logic [31:0]      out_quo,
  output scc_pkg::side_t   out_side
);

  localparam int unsigned N = scc_pkg::DIV_STAGES;

  logic           vld_r  [0:N-1];
  logic [31:0]    rem_r  [0:N-1];
  logic [31:0]    num_r  [0:N-1];
  logic [31:0]    den_r  [0:N-1];
  logic [31:0]    quo_r  [0:N-1];
  scc_pkg::side_t side_r [0:N-1];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stg
      logic           pv;
      logic [31:0]    pr, pn, pd, pq;
      scc_pkg::side_t ps;
      logic [32:0]    tr;
      logic           ge;
      if (k == 0) begin : g_first
        assign pv = in_vld;
        assign pr = '0;
        assign pn = in_num;
        assign pd = in_den;
        assign pq = '0;
        assign ps = in_side;
      end else begin : g_next
        assign pv = vld_r[k-1];
        assign pr = rem_r[k-1];
        assign pn = num_r[k-1];
        assign pd = den_r[k-1];
        assign pq = quo_r[k-1];
        assign ps = side_r[k-1];
      end
      assign tr = {pr, pn[31]};
      assign ge = (tr >= {1'b0, pd});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        rem_r[k]  <= ge ? 32'(tr - {1'b0, pd}) : tr[31:0];
        num_r[k]  <= {pn[30:0], 1'b0};
        den_r[k]  <= pd;
        quo_r[k]  <= {pq[30:0], ge};
        side_r[k] <= ps;
      end
    end
  endgenerate

  assign out_vld  = vld_r[N-1];
  assign out_quo  = quo_r[N-1];
  assign out_side = side_r[N-1];

endmodule

[hdl/sensor_calibration_compensator_top.sv]
// ----------------------------------------------------------------------------
// sensor_calibration_compensator_top
// Integer temperature / pressure / humidity compensation, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | ports                               | handshake
//  input   | start, busy, in_raw_*               | start && !busy
//  result  | out_valid, out_*                    | one-cycle strobe
//  config  | cfg_we, cfg_addr, cfg_wdata         | write when cfg_we
//
// One item per cycle; 11 arithmetic stages, 32 divider
// stages (one quotient bit each), 4 post stages.
// busy stays low; the pipeline never stalls since the receiver cannot.
// Synchronous reset clears valid bits and calibration registers.
module sensor_calibration_compensator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  input  logic [15:0] in_raw_humidity,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  output logic        out_valid,
  output logic signed [14:0] out_compensated_temperature,
  output logic [16:0] out_compensated_pressure,
  output logic [16:0] out_compensated_humidity,
  output logic signed [31:0] out_fine_temperature
);

  localparam logic [2:0] REG_T  = 3'd0;
  localparam logic [2:0] REG_PL = 3'd1;
  localparam logic [2:0] REG_PH = 3'd2;
  localparam logic [2:0] REG_M  = 3'd3;
  localparam logic [2:0] REG_H  = 3'd4;

  logic [47:0] cal_t_r;
  logic [63:0] cal_pl_r, cal_ph_r;
  logic [47:0] cal_m_r;
  logic [31:0] cal_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t_r  <= '0;
      cal_pl_r <= '0;
      cal_ph_r <= '0;
      cal_m_r  <= '0;
      cal_h_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_T:   cal_t_r  <= cfg_wdata[47:0];
        REG_PL:  cal_pl_r <= cfg_wdata;
        REG_PH:  cal_ph_r <= cfg_wdata;
        REG_M:   cal_m_r  <= cfg_wdata[47:0];
        REG_H:   cal_h_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // coefficients, sign- or zero-extended to 32 bits
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, cal_t_r[15:0]};
  assign t2 = {{16{cal_t_r[31]}}, cal_t_r[31:16]};
  assign t3 = {{16{cal_t_r[47]}}, cal_t_r[47:32]};
  assign p1 = {16'd0, cal_pl_r[15:0]};
  assign p2 = {{16{cal_pl_r[31]}}, cal_pl_r[31:16]};
  assign p3 = {{16{cal_pl_r[47]}}, cal_pl_r[47:32]};
  assign p4 = {{16{cal_pl_r[63]}}, cal_pl_r[63:48]};
  assign p5 = {{16{cal_ph_r[15]}}, cal_ph_r[15:0]};
  assign p6 = {{16{cal_ph_r[31]}}, cal_ph_r[31:16]};
  assign p7 = {{16{cal_ph_r[47]}}, cal_ph_r[47:32]};
  assign p8 = {{16{cal_ph_r[63]}}, cal_ph_r[63:48]};
  assign p9 = {{16{cal_m_r[15]}}, cal_m_r[15:0]};
  assign h1 = {24'd0, cal_m_r[23:16]};
  assign h2 = {{16{cal_m_r[39]}}, cal_m_r[39:24]};
  assign h3 = {24'd0, cal_m_r[47:40]};
  assign h4 = {{20{cal_h_r[11]}}, cal_h_r[11:0]};
  assign h5 = {{20{cal_h_r[23]}}, cal_h_r[23:12]};
  assign h6 = {{24{cal_h_r[31]}}, cal_h_r[31:24]};

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic [11:1] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[10:1], accept};
    end
  end

  // S1
  logic [31:0] a1_r, d1_r;
  logic [19:0] ap1_r;
  logic [15:0] ah1_r;
  always_ff @(posedge clk) begin
    a1_r  <= ({12'd0, in_raw_temperature} >> 3) - (t1 << 1);
    d1_r  <= ({12'd0, in_raw_temperature} >> 4) - t1;
    ap1_r <= in_raw_pressure;
    ah1_r <= in_raw_humidity;
  end

  // S2
  logic [31:0] m1_r, dd_r;
  logic [19:0] ap2_r;
  logic [15:0] ah2_r;
  always_ff @(posedge clk) begin
    m1_r  <= a1_r * t2;
    dd_r  <= d1_r * d1_r;
    ap2_r <= ap1_r;
    ah2_r <= ah1_r;
  end

  // S3
  logic [31:0] v1_r, m2_r;
  logic [19:0] ap3_r;
  logic [15:0] ah3_r;
  always_ff @(posedge clk) begin
    v1_r  <= 32'($signed(m1_r) >>> 11);
    m2_r  <= 32'($signed(dd_r) >>> 12) * t3;
    ap3_r <= ap2_r;
    ah3_r <= ah2_r;
  end

  // S4: fine temperature
  logic [31:0] tf4_r;
  logic [19:0] ap4_r;
  logic [15:0] ah4_r;
  always_ff @(posedge clk) begin
    tf4_r <= v1_r + 32'($signed(m2_r) >>> 14);
    ap4_r <= ap3_r;
    ah4_r <= ah3_r;
  end

  // S5: temperature output, pressure and humidity offsets
  logic [31:0] tsc, tmp32;
  assign tsc   = tf4_r * 32'd5 + 32'd128;
  assign tmp32 = 32'($signed(tsc) >>> 8);

  logic [14:0] temp5_r;
  logic [31:0] tf5_r, pv5_r, hx5_r;
  logic [19:0] ap5_r;
  logic [15:0] ah5_r;
  always_ff @(posedge clk) begin
    if ($signed(tmp32) < -32'sd4000) begin
      temp5_r <= -15'sd4000;
    end else if ($signed(tmp32) > 32'sd8500) begin
      temp5_r <= 15'sd8500;
    end else begin
      temp5_r <= tmp32[14:0];
    end
    tf5_r <= tf4_r;
    pv5_r <= 32'($signed(tf4_r) >>> 1) - 32'd64000;
    hx5_r <= tf4_r - 32'd76800;
    ap5_r <= ap4_r;
    ah5_r <= ah4_r;
  end

  // S6
  logic [31:0] q6;
  assign q6 = 32'($signed(pv5_r) >>> 2);

  logic [31:0] q2_r, mp5_r, mp2_r, hx5m_r, xh6_r, xh3_r, tf6_r;
  logic [14:0] temp6_r;
  logic [19:0] ap6_r;
  logic [15:0] ah6_r;
  always_ff @(posedge clk) begin
    q2_r    <= q6 * q6;
    mp5_r   <= pv5_r * p5;
    mp2_r   <= p2 * pv5_r;
    hx5m_r  <= h5 * hx5_r;
    xh6_r   <= hx5_r * h6;
    xh3_r   <= hx5_r * h3;
    tf6_r   <= tf5_r;
    temp6_r <= temp5_r;
    ap6_r   <= ap5_r;
    ah6_r   <= ah5_r;
  end

  // S7
  logic [31:0] hpre;
  assign hpre = ({16'd0, ah6_r} << 14) - (h4 << 20) - hx5m_r + 32'd16384;

  logic [31:0] v2a_r, v2b_r, pp3_r, ha7_r, t6_r, t3h_r, mp2b_r, tf7_r;
  logic [14:0] temp7_r;
  logic [19:0] ap7_r;
  always_ff @(posedge clk) begin
    v2a_r   <= 32'($signed(q2_r) >>> 11) * p6;
    v2b_r   <= mp5_r << 1;
    pp3_r   <= p3 * 32'($signed(q2_r) >>> 13);
    ha7_r   <= 32'($signed(hpre) >>> 15);
    t6_r    <= 32'($signed(xh6_r) >>> 10);
    t3h_r   <= 32'($signed(xh3_r) >>> 11) + 32'd32768;
    mp2b_r  <= mp2_r;
    tf7_r   <= tf6_r;
    temp7_r <= temp6_r;
    ap7_r   <= ap6_r;
  end

  // S8
  logic [31:0] pvs;
  assign pvs = 32'($signed(pp3_r) >>> 3) + 32'($signed(mp2b_r) >>> 1);

  logic [31:0] v2_r, pv8_r, hm_r, ha8_r, tf8_r;
  logic [14:0] temp8_r;
  logic [19:0] ap8_r;
  always_ff @(posedge clk) begin
    v2_r    <= v2a_r + v2b_r;
    pv8_r   <= 32'($signed(pvs) >>> 18);
    hm_r    <= t6_r * t3h_r;
    ha8_r   <= ha7_r;
    tf8_r   <= tf7_r;
    temp8_r <= temp7_r;
    ap8_r   <= ap7_r;
  end

  // S9
  logic [31:0] v2c_r, pv9_r, hbm_r, ha9_r, tf9_r;
  logic [14:0] temp9_r;
  logic [19:0] ap9_r;
  always_ff @(posedge clk) begin
    v2c_r   <= 32'($signed(v2_r) >>> 2) + (p4 << 16);
    pv9_r   <= 32'd32768 + pv8_r;
    hbm_r   <= (32'($signed(hm_r) >>> 10) + 32'd2097152) * h2;
    ha9_r   <= ha8_r;
    tf9_r   <= tf8_r;
    temp9_r <= temp8_r;
    ap9_r   <= ap8_r;
  end

  // S10
  logic [31:0] hbs;
  assign hbs = hbm_r + 32'd8192;

  logic [31:0] pm1_r, pnum_r, hb_r, ha10_r, tf10_r;
  logic [14:0] temp10_r;
  always_ff @(posedge clk) begin
    pm1_r    <= pv9_r * p1;
    pnum_r   <= (32'd1048576 - {12'd0, ap9_r}) - 32'($signed(v2c_r) >>> 12);
    hb_r     <= 32'($signed(hbs) >>> 14);
    ha10_r   <= ha9_r;
    tf10_r   <= tf9_r;
    temp10_r <= temp9_r;
  end

  // S11
  logic [31:0] dv_r, pn3_r, hx11_r, tf11_r;
  logic [14:0] temp11_r;
  always_ff @(posedge clk) begin
    dv_r     <= 32'($signed(pm1_r) >>> 15);
    pn3_r    <= pnum_r * 32'd3125;
    hx11_r   <= ha10_r * hb_r;
    tf11_r   <= tf10_r;
    temp11_r <= temp10_r;
  end

  // divider
  scc_pkg::side_t div_side, dq_side;
  logic [31:0]    div_num, dq_quo;
  logic           dq_vld;
  assign div_side.zero = (dv_r == 32'd0);
  assign div_side.big  = pn3_r[31];
  assign div_side.temp = temp11_r;
  assign div_side.tf   = tf11_r;
  assign div_side.hx   = hx11_r;
  assign div_num       = pn3_r[31] ? pn3_r : (pn3_r << 1);

  scc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_r[11]),
    .in_num   (div_num),
    .in_den   (dv_r),
    .in_side  (div_side),
    .out_vld  (dq_vld),
    .out_quo  (dq_quo),
    .out_side (dq_side)
  );

  // post stages
  logic [3:1] pv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[2:1], dq_vld};
    end
  end

  scc_pkg::side_t s1_r, s2_r, s3_r;
  logic [31:0] pp1_r, y1_r;
  always_ff @(posedge clk) begin
    pp1_r <= dq_side.big ? (dq_quo << 1) : dq_quo;
    y1_r  <= 32'($signed(dq_side.hx) >>> 15);
    s1_r  <= dq_side;
  end

  logic [31:0] p8d, sq_r, w2m_r, yy_r, pp2_r;
  assign p8d = pp1_r >> 3;
  always_ff @(posedge clk) begin
    sq_r  <= p8d * p8d;
    w2m_r <= (pp1_r >> 2) * p8;
    yy_r  <= y1_r * y1_r;
    pp2_r <= pp1_r;
    s2_r  <= s1_r;
  end

  logic [31:0] w1m_r, w2_r, hm2_r, pp3b_r;
  always_ff @(posedge clk) begin
    w1m_r  <= p9 * (sq_r >> 13);
    w2_r   <= 32'($signed(w2m_r) >>> 13);
    hm2_r  <= 32'($signed(yy_r) >>> 7) * h1;
    pp3b_r <= pp2_r;
    s3_r   <= s2_r;
  end

  logic [31:0] wsum, pfin, hxf, hcl;
  assign wsum = 32'($signed(w1m_r) >>> 12) + w2_r + p7;
  assign pfin = pp3b_r + 32'($signed(wsum) >>> 4);
  assign hxf  = s3_r.hx - 32'($signed(hm2_r) >>> 4);
  assign hcl  = $signed(hxf) < 0 ? 32'd0 :
                (hxf > scc_pkg::HUM_PRE_MAX ? scc_pkg::HUM_PRE_MAX : hxf);

  logic [16:0] pres_r, hum_r;
  logic [14:0] temp_r;
  logic [31:0] tf_r;
  always_ff @(posedge clk) begin
    if (s3_r.zero || $signed(pfin) < 0) begin
      pres_r <= '0;
    end else if (pfin > scc_pkg::PRES_MAX) begin
      pres_r <= scc_pkg::PRES_MAX[16:0];
    end else begin
      pres_r <= pfin[16:0];
    end
    hum_r  <= hcl[28:12];
    temp_r <= s3_r.temp;
    tf_r   <= s3_r.tf;
  end

  logic out_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= pv_r[3];
    end
  end

  assign out_valid                   = out_vld_r;
  assign out_compensated_temperature = $signed(temp_r);
  assign out_compensated_pressure    = pres_r;
  assign out_compensated_humidity    = hum_r;
  assign out_fine_temperature        = $signed(tf_r);

`ifndef SYNTHESIS
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_compensated_temperature >= -15'sd4000 &&
                   out_compensated_temperature <= 15'sd8500))
    else $error("temperature out of range");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_compensated_humidity <= 17'd102400))
    else $error("humidity out of range");

  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r[3] && s3_r.zero) |=> (out_compensated_pressure == 17'd0))
    else $error("pressure not zero for zero divisor");

  a_post_vld: assert property (@(posedge clk) disable iff (!rst_n)
    dq_vld |=> pv_r[1])
    else $error("post stage lost an item");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw samples into the sensor compensator across several calibration
// sets and checks every compensated sample against a local integer model.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] REG_TEMP   = 3'd0;
  localparam logic [2:0] REG_PLOW   = 3'd1;
  localparam logic [2:0] REG_PHIGH  = 3'd2;
  localparam logic [2:0] REG_MIXED  = 3'd3;
  localparam logic [2:0] REG_HUM    = 3'd4;
  localparam logic [2:0] REG_BOGUS  = 3'd7;
  localparam int LATENCY   = 47;
  localparam int WDOG_MAX  = 2000;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [16:0]        pres;
    logic [16:0]        hum;
    logic signed [31:0] tf;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [19:0] in_raw_temperature = '0;
  logic [19:0] in_raw_pressure = '0;
  logic [15:0] in_raw_humidity = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;
  logic        out_valid;
  logic signed [14:0] out_compensated_temperature;
  logic [16:0] out_compensated_pressure;
  logic [16:0] out_compensated_humidity;
  logic signed [31:0] out_fine_temperature;

  logic [63:0] cal_regs [0:4];
  sample_t     pending_samples [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          gaps_on = 1'b1;

  sensor_calibration_compensator_top u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] sra(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx(input logic [63:0] w, input int lo, input int bits);
    logic [31:0] f;
    f = 32'((w >> lo) & ((64'd1 << bits) - 1));
    return (f ^ (32'd1 << (bits - 1))) - (32'd1 << (bits - 1));
  endfunction

  function automatic logic [31:0] zx(input logic [63:0] w, input int lo, input int bits);
    return 32'((w >> lo) & ((64'd1 << bits) - 1));
  endfunction

  function automatic sample_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                         input logic [15:0] rh);
    logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6, v1, v2, d, tf, tmp, q, q2, p, x, y, a, b, w1, w2;
    sample_t r;
    at = 32'(rt); ap = 32'(rp); ah = 32'(rh);
    t1 = zx(cal_regs[0], 0, 16);  t2 = sx(cal_regs[0], 16, 16); t3 = sx(cal_regs[0], 32, 16);
    p1 = zx(cal_regs[1], 0, 16);  p2 = sx(cal_regs[1], 16, 16);
    p3 = sx(cal_regs[1], 32, 16); p4 = sx(cal_regs[1], 48, 16);
    p5 = sx(cal_regs[2], 0, 16);  p6 = sx(cal_regs[2], 16, 16);
    p7 = sx(cal_regs[2], 32, 16); p8 = sx(cal_regs[2], 48, 16);
    p9 = sx(cal_regs[3], 0, 16);  h1 = zx(cal_regs[3], 16, 8);
    h2 = sx(cal_regs[3], 24, 16); h3 = zx(cal_regs[3], 40, 8);
    h4 = sx(cal_regs[4], 0, 12);  h5 = sx(cal_regs[4], 12, 12); h6 = sx(cal_regs[4], 24, 8);

    v1 = sra(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    v2 = sra(sra(d * d, 12) * t3, 14);
    tf = v1 + v2;
    tmp = sra(tf * 32'd5 + 32'd128, 8);
    if ($signed(tmp) < -4000) tmp = -32'sd4000;
    else if ($signed(tmp) > 8500) tmp = 32'd8500;

    v1 = sra(tf, 1) - 32'd64000;
    q = sra(v1, 2);
    q2 = q * q;
    v2 = sra(q2, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra(v2, 2) + (p4 << 16);
    v1 = sra(sra(p3 * sra(q2, 13), 3) + sra(p2 * v1, 1), 18);
    v1 = sra((32'd32768 + v1) * p1, 15);
    if (v1 == 0) begin
      p = 0;
    end else begin
      p = ((32'd1048576 - ap) - sra(v2, 12)) * 32'd3125;
      if (!p[31]) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      w1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      w2 = sra((p >> 2) * p8, 13);
      p = p + sra(w1 + w2 + p7, 4);
      if (p[31]) p = 0;
      else if (p > 32'd131071) p = 32'd131071;
    end

    x = tf - 32'd76800;
    a = sra((ah << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
    b = sra((sra(sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768), 10) + 32'd2097152) * h2
            + 32'd8192, 14);
    x = a * b;
    y = sra(x, 15);
    x = x - sra(sra(y * y, 7) * h1, 4);
    if (x[31]) x = 0;
    if (x > 32'd419430400) x = 32'd419430400;

    r.temp = tmp[14:0];
    r.pres = p[16:0];
    r.hum = 17'(x >> 12);
    r.tf = tf;
    return r;
  endfunction

  task automatic write_cal(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TEMP, REG_MIXED: cal_regs[idx] = val & 64'hFFFF_FFFF_FFFF;
      REG_PLOW, REG_PHIGH: cal_regs[idx] = val;
      REG_HUM:             cal_regs[idx] = val & 64'hFFFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic load_cal(input logic [63:0] tw, input logic [63:0] pl, input logic [63:0] ph,
                          input logic [63:0] mw, input logic [63:0] hw);
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
    write_cal(REG_TEMP, tw);
    write_cal(REG_PLOW, pl);
    write_cal(REG_PHIGH, ph);
    write_cal(REG_MIXED, mw);
    write_cal(REG_HUM, hw);
  endtask

  // one item; predicted result is queued at the accepting edge
  task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
                             input logic [15:0] rh);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_raw_temperature <= rt;
    in_raw_pressure <= rp;
    in_raw_humidity <= rh;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_samples.push_back(compensate(rt, rp, rh));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item");
      end else begin
        want = pending_samples.pop_front();
        if (want.temp !== out_compensated_temperature || want.pres !== out_compensated_pressure
            || want.hum !== out_compensated_humidity || want.tf !== out_fine_temperature) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp t=%0d p=%0d h=%0d tf=%0d got t=%0d p=%0d h=%0d tf=%0d",
                     want.temp, want.pres, want.hum, want.tf,
                     out_compensated_temperature, out_compensated_pressure,
                     out_compensated_humidity, out_fine_temperature);
        end
      end
    end
  end

  // watchdog on cycles with results pending but no accepted item, result or config write
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || pending_samples.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  // typical calibration seen on production parts
  task automatic test_typical_cal();
    load_cal({16'hFC18, 16'h6A5C, 16'd27504},
             {16'd2855, 16'hD0C1, 16'hD67A, 16'd36477},
             {16'hE8AA, 16'h3C70, 16'hFFF9, 16'hFF8C},
             {8'd0, 16'd362, 8'd75, 16'd6000},
             {8'd30, 12'd50, 12'd317});
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd400000, 20'd0, 16'hFFFF);
    send_sample(20'd600000, 20'hFFFFF, 16'd0);
    stop_sending();
  endtask

  // zero divisor (P1 = 0), out-of-range index write and reset-like zeros
  task automatic test_zero_divisor();
    load_cal(64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
    write_cal(REG_BOGUS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
    stop_sending();
  endtask

  // all-ones and sign-extreme coefficients drive saturation and wrap
  task automatic test_extreme_cal();
    load_cal({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'h80000, 20'h80000, 16'h8000);
    stop_sending();
    load_cal(64'h8000_7FFF_0001, 64'h7FFF_8000_7FFF_FFFF, 64'h8000_7FFF_8000_7FFF,
             64'hFF_7FFF_FF_8000, 64'h80_7FF_800);
    send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
    send_sample(20'hFFFFF, 20'd0, 16'd0);
    send_sample(20'h55555, 20'hAAAAA, 16'h5A5A);
    stop_sending();
  endtask

  // random raw samples over random calibration sets, typical values weighted
  task automatic test_random_samples();
    logic [63:0] tw, pl, mw;
    for (int set = 0; set < 6; set++) begin
      tw = {$urandom(), $urandom()};
      pl = {$urandom(), $urandom()};
      mw = {$urandom(), $urandom()};
      if (set % 2 == 0) begin
        tw[15:0] = 16'($urandom_range(20000, 32000));
        pl[15:0] = 16'($urandom_range(30000, 40000));
      end
      load_cal(tw, pl, {$urandom(), $urandom()}, mw, 64'($urandom()));
      gaps_on = (set != 2);
      for (int n = 0; n < 310; n++) begin
        if (n % 4 != 0)
          send_sample(20'($urandom_range(350000, 650000)), 20'($urandom_range(200000, 600000)),
                      16'($urandom()));
        else
          send_sample(20'($urandom()), 20'($urandom()), 16'($urandom()));
      end
      stop_sending();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 5; i++) cal_regs[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_typical_cal();
    test_zero_divisor();
    test_extreme_cal();
    test_random_samples();
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[sensor_calibration_compensator_top.f]
hdl/scc_pkg.sv
hdl/scc_div.sv
hdl/sensor_calibration_compensator_top.sv
bench/testbench.sv
